// ===== rtl/core/wildcard_glob_matcher_macros.svh =====
// Assertion macros for the wildcard glob matcher
`ifndef WILDCARD_GLOB_MATCHER_MACROS_SVH
`define WILDCARD_GLOB_MATCHER_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define WGM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true out of reset
`define WGM_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define WGM_ASSERT(label, clk, rst_n, prop, msg)
`define WGM_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ===== rtl/core/wgm_pkg.sv =====
// Shared types, constants and helpers for the wildcard glob matcher
package wgm_pkg;

    localparam int PAT_REGS  = 4;
    localparam int REG_BYTES = 32;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef enum logic [2:0] {
        REG_PAT0 = 3'd0,
        REG_PAT1 = 3'd1,
        REG_PAT2 = 3'd2,
        REG_PAT3 = 3'd3,
        REG_LEN  = 3'd4
    } cfg_reg_t;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic use_start;  // current set is the start closure
        logic advance;    // load the stepped set into the cells
    } wgm_ctl_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z)
        begin
            r = c - CASE_OFS;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/wgm_cell.sv =====
// One pattern position: holds its active bit and passes a match to the next position
module wgm_cell
    import wgm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  wgm_ctl_t   ctl,
    input  logic [7:0] subject,
    input  logic [7:0] pat_byte,
    input  logic       in_use,
    input  logic       adv_in,
    input  logic       start_in,
    input  logic       closed_in,
    output logic       adv_out,
    output logic       raw,
    output logic       star,
    output logic       cur
);

    logic active_reg;
    logic active_next;
    logic is_star;
    logic byte_hit;

    assign cur      = ctl.use_start ? start_in : active_reg;
    assign is_star  = in_use && (pat_byte == CH_STAR);
    assign byte_hit = (pat_byte == CH_QMARK) || (fold_case(pat_byte) == subject);

    assign adv_out = in_use && cur && !is_star && byte_hit;
    assign raw     = (cur && is_star) || adv_in;
    assign star    = is_star;

    assign active_next = ctl.advance ? closed_in : active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

endmodule

// ===== rtl/core/wgm_closure.sv =====
// Star closure over the position vector, done as the carry chain of one add
module wgm_closure #(
    parameter int W = 33
) (
    input  logic [W-1:0] set_in,
    input  logic [W-1:0] star,
    output logic [W-1:0] closed
);

    logic [W:0] gen_ext;
    logic [W:0] prop_ext;
    logic [W:0] sum;
    logic [W:0] carry;

    // carry into i+1 = star[i] & (set[i] | carry[i]): generate = star & set
    assign prop_ext = {1'b0, star};
    assign gen_ext  = {1'b0, star & set_in};
    assign sum      = prop_ext + gen_ext;
    assign carry    = sum ^ prop_ext ^ gen_ext;
    assign closed   = set_in | carry[W-1:0];

endmodule

// ===== rtl/core/wildcard_glob_matcher.sv =====
// Top level of the wildcard glob matcher: config registers, cell row, result register
// Matches a subject string, one byte per input transfer, against a configured glob
// pattern of up to 32 bytes ('*' any run, '?' one byte, letters case-insensitive).
// A result transfer carries one match flag for each string, produced on the transfer
// marked last_byte or empty_string. The block takes one byte per clock while
// in_ready is high: every pattern position is a cell that updates its active bit,
// with star runs resolved by one carry chain across the row. The flag sits in the
// result register from the cycle after the final transfer; while out_ready is high
// the next string follows with no gap, and a flag that is not taken stalls the input
// until it is. A write to one of the five listed registers restarts the matcher;
// any configuration write holds in_ready low in the cycle after it, while the start
// set of the new pattern is registered.
`include "wildcard_glob_matcher_macros.svh"

module wildcard_glob_matcher
    import wgm_pkg::*;
#(
    parameter int PATTERN_MAX = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  subject_byte,
    input  logic        last_byte,
    input  logic        empty_string,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        matched,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int N   = PATTERN_MAX;
    localparam int CAP = (N < REG_BYTES) ? N : REG_BYTES;
    localparam int LW  = 7;
    localparam logic [5:0] CAP_L = 6'(CAP);

    logic [63:0] pat_reg [PAT_REGS];
    logic [5:0]  len_reg;
    logic [5:0]  eff_len;

    logic        start_ok_reg;
    logic        start_ok_next;
    logic        start_pend_reg;
    logic        start_pend_next;
    logic [N:0]  start_reg;
    logic        fin_reg;
    logic        fin_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        matched_reg;
    logic        matched_next;

    logic        in_fire;
    logic        cfg_fire;
    logic        cfg_hit;
    logic        str_end;
    logic [7:0]  subj_fold;
    wgm_ctl_t    ctl;

    logic [N:0]  raw_vec;
    logic [N:0]  star_vec;
    logic [N:0]  cur_vec;
    logic [N:0]  closed_vec;
    logic [N:0]  start_vec;
    logic [N:0]  seed_vec;
    logic [N:0]  final_sel;
    logic [N:0]  in_range;
    logic [N-1:0] adv_vec;

    assign in_fire  = in_valid && in_ready;
    assign cfg_fire = cfg_valid && cfg_ready;
    // only writes to a listed register restart the matcher
    assign cfg_hit  = cfg_fire &&
                      (cfg_reg_t'(cfg_index) inside {REG_PAT0, REG_PAT1, REG_PAT2,
                                                     REG_PAT3, REG_LEN});
    assign str_end  = last_byte || empty_string;
    assign subj_fold = fold_case(subject_byte);

    assign cfg_ready = 1'b1;
    assign in_ready  = start_ok_reg && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

    assign eff_len = (len_reg > CAP_L) ? CAP_L : len_reg;

    assign ctl.use_start = start_pend_reg;
    assign ctl.advance   = in_fire && !str_end;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < PAT_REGS; r++)
            begin
                pat_reg[r] <= '0;
            end
            len_reg <= '0;
        end
        else if (cfg_fire)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PAT0: pat_reg[0] <= cfg_data;
                REG_PAT1: pat_reg[1] <= cfg_data;
                REG_PAT2: pat_reg[2] <= cfg_data;
                REG_PAT3: pat_reg[3] <= cfg_data;
                REG_LEN:  len_reg    <= cfg_data[5:0];
                default:  ;
            endcase
        end
    end

    // cell row
    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            logic [7:0] pbyte;
            logic       adv_in;

            if (gi < REG_BYTES)
            begin : g_byte
                assign pbyte = pat_reg[gi / 8][(gi % 8) * 8 +: 8];
            end
            else
            begin : g_zero
                assign pbyte = 8'h00;
            end

            if (gi == 0)
            begin : g_head
                assign adv_in = 1'b0;
            end
            else
            begin : g_link
                assign adv_in = adv_vec[gi-1];
            end

            assign in_range[gi]  = ({1'b0, eff_len} > LW'(gi));

            wgm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .subject   (subj_fold),
                .pat_byte  (pbyte),
                .in_use    (in_range[gi]),
                .adv_in    (adv_in),
                .start_in  (start_reg[gi]),
                .closed_in (closed_vec[gi]),
                .adv_out   (adv_vec[gi]),
                .raw       (raw_vec[gi]),
                .star      (star_vec[gi]),
                .cur       (cur_vec[gi])
            );
        end

        for (gi = 0; gi <= N; gi++)
        begin : g_final
            assign final_sel[gi] = ({1'b0, eff_len} == LW'(gi));
        end
    endgenerate

    // position N has no pattern byte: it only receives
    assign in_range[N] = 1'b0;
    assign raw_vec[N]  = adv_vec[N-1];
    assign star_vec[N] = 1'b0;
    assign cur_vec[N]  = start_pend_reg ? start_reg[N] : fin_reg;
    assign seed_vec    = {{N{1'b0}}, 1'b1};

    wgm_closure #(.W(N + 1)) u_step_closure (
        .set_in (raw_vec),
        .star   (star_vec),
        .closed (closed_vec)
    );

    wgm_closure #(.W(N + 1)) u_start_closure (
        .set_in (seed_vec),
        .star   (star_vec),
        .closed (start_vec)
    );

    always_comb
    begin
        start_ok_next   = !cfg_fire;
        start_pend_next = start_pend_reg;
        fin_next        = fin_reg;
        if (cfg_hit)
        begin
            start_pend_next = 1'b1;
        end
        else if (in_fire)
        begin
            start_pend_next = str_end;
            if (!str_end)
            begin
                fin_next = closed_vec[N];
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        matched_next   = matched_reg;
        if (in_fire && str_end)
        begin
            out_valid_next = 1'b1;
            matched_next   = empty_string ? |(start_reg & final_sel)
                                          : |(closed_vec & final_sel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_ok_reg   <= 1'b0;
            start_pend_reg <= 1'b1;
            fin_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            start_ok_reg   <= start_ok_next;
            start_pend_reg <= start_pend_next;
            fin_reg        <= fin_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg   <= start_vec;
        matched_reg <= matched_next;
    end

    `WGM_ASSERT(a_end_gives_result, clk, rst_n, in_fire && str_end |=> out_valid_reg, "string end without result")
    `WGM_ASSERT(a_mid_no_result, clk, rst_n, in_fire && !str_end && !out_valid_reg |=> !out_valid_reg, "result on a middle byte")
    `WGM_ASSERT(a_cfg_blocks_input, clk, rst_n, cfg_fire |=> !in_ready, "input taken before start set is ready")
    `WGM_ASSERT_NEVER(a_no_pos_past_len, clk, rst_n, !start_pend_reg && ((cur_vec & ~(in_range | final_sel)) != '0), "active position beyond pattern length")

endmodule
